// ===== hdl/sd_card_spi_host_engine_unit_defines.svh =====
// ----------------------------------------------------------------------------
// SD card SPI host engine: assertion macros
// Shared assertion forms for the checker of the host engine.
// ----------------------------------------------------------------------------
`ifndef SD_CARD_SPI_HOST_ENGINE_UNIT_DEFINES_SVH
`define SD_CARD_SPI_HOST_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SDSPI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SDSPI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/sdspi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD card SPI host engine package
// Types, widths and helpers shared by the host engine modules.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int BC_W = $clog2(BLOCK_BYTES + 4);

  // Configuration register indexes.
  localparam logic [2:0] REG_INIT_TO  = 3'd0;
  localparam logic [2:0] REG_READ_TO  = 3'd1;
  localparam logic [2:0] REG_WRITE_TO = 3'd2;
  localparam logic [2:0] REG_ERASE_TO = 3'd3;
  localparam logic [2:0] REG_FLUSH_TO = 3'd4;
  localparam logic [2:0] REG_TRIES    = 3'd5;
  localparam logic [2:0] REG_PROTECT  = 3'd6;

  // Input command codes.
  localparam logic [1:0] CMD_REQUEST = 2'd0;
  localparam logic [1:0] CMD_BYTE    = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  // Word classes as seen by the back end.
  localparam logic [1:0] CLS_REQUEST = 2'd0;
  localparam logic [1:0] CLS_BYTE    = 2'd1;
  localparam logic [1:0] CLS_TICK    = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  op;
    logic [31:0] block_addr;
    logic [31:0] last_block;
    logic [7:0]  rx_byte;
    logic [7:0]  wr_byte;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        cs_low;
    logic        rd_valid;
    logic [7:0]  rd_byte;
    logic        wr_ready;
    logic        done_res;
    logic        ok;
    logic [3:0]  error_code;
    logic [1:0]  card_type;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  cls;
    logic [1:0]  op;
    logic [31:0] block_addr;
    logic [31:0] last_block;
    logic [7:0]  rx_byte;
    logic [7:0]  wr_byte;
  } q_item_t;

  // Byte b of the six-byte command frame.
  function automatic logic [7:0] cmd_byte(input logic [2:0] b, input logic [5:0] idx,
                                          input logic [31:0] arg);
    logic [7:0] r;
    case (b)
      3'd0: r = {2'b01, idx};
      3'd1: r = arg[31:24];
      3'd2: r = arg[23:16];
      3'd3: r = arg[15:8];
      3'd4: r = arg[7:0];
      default: begin
        if (idx == 6'd0) r = 8'h95;
        else if (idx == 6'd8) r = 8'h87;
        else r = 8'hff;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/sdspi_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD card SPI host engine channels
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface sdspi_in_if;
  import sdspi_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sdspi_out_if;
  import sdspi_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sdspi_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/sd_card_spi_host_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD card SPI host engine
// Byte-level SPI-mode host sequencer for init, block read, write and erase.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  item     in         host request, received SPI byte or millisecond tick
//  result   out        next transfer, read data, write-data request, completion
//  cfg      in         register index and write data, always ready
//
// A new word may enter every cycle while the queue has room; words pass through
// a two-entry queue, and the sequencer's result sits in an output register, so
// the input can still fill the queue while one result waits to be taken.
// Reset is synchronous and returns the sequencer to idle with default registers.
module sd_card_spi_host_engine_unit (
  input  logic        clk,
  input  logic        rst,
  sdspi_in_if.sink    item,
  sdspi_out_if.source result,
  sdspi_cfg_if.sink   cfg
);
  import sdspi_pkg::*;

  logic    q_valid;
  logic    q_pop;
  q_item_t q_head;

  sdspi_front u_front (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .q_valid(q_valid),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  sdspi_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_head (q_head),
    .q_pop  (q_pop),
    .cfg    (cfg),
    .result (result)
  );

endmodule

// ===== hdl/sdspi_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD card SPI host engine front end
// Accepts input words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module sdspi_front (
  input  logic              clk,
  input  logic              rst,
  sdspi_in_if.sink          item,
  output logic              q_valid,
  output sdspi_pkg::q_item_t q_head,
  input  logic              q_pop
);
  import sdspi_pkg::*;

  q_item_t    slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       push;
  q_item_t    cls_item;

  assign item.ready = (count != 2'd2);
  assign push = item.valid && item.ready;
  assign q_valid = (count != 2'd0);
  assign q_head = slots[rp];

  always_comb begin
    cls_item.op = item.data.op;
    cls_item.block_addr = item.data.block_addr;
    cls_item.last_block = item.data.last_block;
    cls_item.rx_byte = item.data.rx_byte;
    cls_item.wr_byte = item.data.wr_byte;
    case (item.data.command)
      CMD_REQUEST: cls_item.cls = CLS_REQUEST;
      CMD_BYTE:    cls_item.cls = CLS_BYTE;
      default:     cls_item.cls = CLS_TICK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= cls_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== hdl/sdspi_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD card SPI host engine back end
// Runs the card sequences one queued word at a time and registers the result.
// ----------------------------------------------------------------------------
module sdspi_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  sdspi_pkg::q_item_t q_head,
  output logic               q_pop,
  sdspi_cfg_if.sink          cfg,
  sdspi_out_if.source        result
);
  import sdspi_pkg::*;

  localparam logic [3:0] P_IDLE = 4'd0, P_CLOCKS = 4'd1, P_FLUSH = 4'd2, P_SEND = 4'd3;
  localparam logic [3:0] P_RESP = 4'd4, P_R7 = 4'd5, P_OCR = 4'd6, P_START = 4'd7;
  localparam logic [3:0] P_DATA = 4'd8, P_CSD = 4'd9, P_CRC = 4'd10, P_WDATA = 4'd11;
  localparam logic [3:0] P_BUSY = 4'd12, P_STAT2 = 4'd13;

  localparam logic [3:0] A_CMD0 = 4'd0, A_CMD8 = 4'd1, A_CMD55 = 4'd2, A_ACMD41 = 4'd3;
  localparam logic [3:0] A_CMD58 = 4'd4, A_CMD17 = 4'd5, A_CMD24 = 4'd6, A_CMD13 = 4'd7;
  localparam logic [3:0] A_CMD9 = 4'd8, A_CMD32 = 4'd9, A_CMD33 = 4'd10, A_CMD38 = 4'd11;

  localparam logic [1:0] OP_INIT = 2'd0, OP_READ = 2'd1, OP_WRITE = 2'd2;
  localparam logic [1:0] CK_SD1 = 2'd1, CK_SD2 = 2'd2, CK_SDHC = 2'd3;

  localparam logic [3:0] E_CMD0 = 4'd1, E_CMD8 = 4'd2, E_ACMD41 = 4'd3, E_CMD58 = 4'd4;
  localparam logic [3:0] E_CMD17 = 4'd5, E_CMD24 = 4'd6, E_WR_TO = 4'd7, E_PROG = 4'd8;
  localparam logic [3:0] E_NO_ERASE = 4'd9, E_ERASE = 4'd10, E_ERASE_TO = 4'd11;
  localparam logic [3:0] E_BLOCK0 = 4'd12, E_GENERAL = 4'd15;

  localparam logic [BC_W-1:0] BC_LAST = BC_W'(BLOCK_BYTES);
  localparam logic [BC_W-1:0] BC_RESP = BC_W'(BLOCK_BYTES + 3);

  // Configuration registers.
  logic [15:0] init_to, read_to, write_to, erase_to, flush_to;
  logic [7:0]  tries;
  logic        protect;

  // Sequencer state.
  logic [3:0]      phase, phase_next;
  logic [1:0]      card_kind, card_kind_next;
  logic [7:0]      last_status, last_status_next;
  logic [15:0]     ms_elapsed, ms_elapsed_next;
  logic [15:0]     flush_ms, flush_ms_next;
  logic [BC_W-1:0] byte_count, byte_count_next;
  logic [7:0]      retry_count, retry_count_next;
  logic [5:0]      cmd_index, cmd_index_next;
  logic [31:0]     cmd_argument, cmd_argument_next;
  logic [31:0]     erase_end_addr, erase_end_addr_next;
  logic [31:0]     erase_start_addr, erase_start_addr_next;
  logic            erase_enabled, erase_enabled_next;
  logic [3:0]      after_step, after_step_next;
  logic [1:0]      req_op, req_op_next;

  logic        out_valid;
  out_item_t   out_data;

  out_item_t   r;
  logic        emit;
  logic        sc_go, fl_go, fin_go, pl_go;
  logic [5:0]  sc_idx;
  logic [31:0] sc_arg;
  logic [3:0]  sc_after;
  logic [3:0]  fl_err;
  logic [BC_W-1:0] bc_inc;
  logic [7:0]  rx;

  function automatic logic [31:0] to_addr(input logic [1:0] ck, input logic [31:0] blk);
    return (ck == CK_SDHC) ? blk : {blk[22:0], 9'd0};
  endfunction

  assign cfg.ready = 1'b1;
  assign q_pop = q_valid && (!out_valid || result.ready);
  assign result.valid = out_valid;
  assign result.data = out_data;
  assign bc_inc = byte_count + 1'b1;
  assign rx = q_head.rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_to <= 16'd2000;
      read_to <= 16'd300;
      write_to <= 16'd600;
      erase_to <= 16'd10000;
      flush_to <= 16'd300;
      tries <= 8'd255;
      protect <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_INIT_TO:  init_to <= cfg.data;
        REG_READ_TO:  read_to <= cfg.data;
        REG_WRITE_TO: write_to <= cfg.data;
        REG_ERASE_TO: erase_to <= cfg.data;
        REG_FLUSH_TO: flush_to <= cfg.data;
        REG_TRIES:    tries <= cfg.data[7:0];
        REG_PROTECT:  protect <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next = phase;
    card_kind_next = card_kind;
    last_status_next = last_status;
    ms_elapsed_next = ms_elapsed;
    flush_ms_next = flush_ms;
    byte_count_next = byte_count;
    retry_count_next = retry_count;
    cmd_index_next = cmd_index;
    cmd_argument_next = cmd_argument;
    erase_end_addr_next = erase_end_addr;
    erase_start_addr_next = erase_start_addr;
    erase_enabled_next = erase_enabled;
    after_step_next = after_step;
    req_op_next = req_op;
    r = '0;
    emit = 1'b0;
    sc_go = 1'b0;
    fl_go = 1'b0;
    fin_go = 1'b0;
    pl_go = 1'b0;
    sc_idx = 6'd0;
    sc_arg = 32'd0;
    sc_after = A_CMD0;
    fl_err = 4'd0;

    case (q_head.cls)
      CLS_REQUEST: begin
        if (phase == P_IDLE) begin
          req_op_next = q_head.op;
          case (q_head.op)
            OP_INIT: begin
              card_kind_next = 2'd0;
              ms_elapsed_next = 16'd0;
              byte_count_next = '0;
              phase_next = P_CLOCKS;
              emit = 1'b1;
              r.tx_valid = 1'b1;
              r.tx_byte = 8'hff;
            end
            OP_READ: begin
              sc_go = 1'b1; sc_idx = 6'd17; sc_after = A_CMD17;
              sc_arg = to_addr(card_kind, q_head.block_addr);
            end
            OP_WRITE: begin
              if (protect && q_head.block_addr == 32'd0) begin
                fl_go = 1'b1; fl_err = E_BLOCK0;
              end else begin
                sc_go = 1'b1; sc_idx = 6'd24; sc_after = A_CMD24;
                sc_arg = to_addr(card_kind, q_head.block_addr);
              end
            end
            default: begin
              erase_start_addr_next = q_head.block_addr;
              erase_end_addr_next = q_head.last_block;
              erase_enabled_next = 1'b0;
              sc_go = 1'b1; sc_idx = 6'd9; sc_after = A_CMD9;
            end
          endcase
        end
      end
      CLS_BYTE: begin
        case (phase)
          P_CLOCKS: begin
            byte_count_next = bc_inc;
            if (bc_inc < BC_W'(10)) begin
              emit = 1'b1;
              r.tx_valid = 1'b1;
              r.tx_byte = 8'hff;
            end else begin
              ms_elapsed_next = 16'd0;
              sc_go = 1'b1; sc_idx = 6'd0; sc_after = A_CMD0;
            end
          end
          P_FLUSH: begin
            if (rx == 8'hff || flush_ms >= flush_to) begin
              phase_next = P_SEND;
              byte_count_next = '0;
              emit = 1'b1;
              r.tx_valid = 1'b1;
              r.cs_low = 1'b1;
              r.tx_byte = cmd_byte(3'd0, cmd_index, cmd_argument);
            end else begin
              pl_go = 1'b1;
            end
          end
          P_SEND: begin
            byte_count_next = bc_inc;
            if (bc_inc < BC_W'(6)) begin
              emit = 1'b1;
              r.tx_valid = 1'b1;
              r.cs_low = 1'b1;
              r.tx_byte = cmd_byte(bc_inc[2:0], cmd_index, cmd_argument);
            end else begin
              phase_next = P_RESP;
              retry_count_next = 8'd0;
              pl_go = 1'b1;
            end
          end
          P_RESP: begin
            last_status_next = rx;
            if (rx[7] && retry_count != tries) begin
              retry_count_next = retry_count + 8'd1;
              pl_go = 1'b1;
            end else begin
              // The response just polled decides the next step.
              case (after_step)
                A_CMD0: begin
                  if (rx == 8'h01) begin
                    sc_go = 1'b1; sc_idx = 6'd8; sc_arg = 32'h1aa; sc_after = A_CMD8;
                  end else if (ms_elapsed > init_to) begin
                    fl_go = 1'b1; fl_err = E_CMD0;
                  end else begin
                    sc_go = 1'b1; sc_idx = 6'd0; sc_after = A_CMD0;
                  end
                end
                A_CMD8: begin
                  if (rx[2]) begin
                    card_kind_next = CK_SD1;
                    sc_go = 1'b1; sc_idx = 6'd55; sc_after = A_CMD55;
                  end else begin
                    phase_next = P_R7;
                    byte_count_next = '0;
                    pl_go = 1'b1;
                  end
                end
                A_CMD55: begin
                  sc_go = 1'b1; sc_idx = 6'd41; sc_after = A_ACMD41;
                  sc_arg = (card_kind == CK_SD2) ? 32'h4000_0000 : 32'd0;
                end
                A_ACMD41: begin
                  if (rx == 8'h00) begin
                    if (card_kind == CK_SD2) begin
                      sc_go = 1'b1; sc_idx = 6'd58; sc_after = A_CMD58;
                    end else begin
                      fin_go = 1'b1;
                    end
                  end else if (ms_elapsed > init_to) begin
                    fl_go = 1'b1; fl_err = E_ACMD41;
                  end else begin
                    sc_go = 1'b1; sc_idx = 6'd55; sc_after = A_CMD55;
                  end
                end
                A_CMD58: begin
                  if (rx != 8'h00) begin
                    fl_go = 1'b1; fl_err = E_CMD58;
                  end else begin
                    phase_next = P_OCR;
                    byte_count_next = '0;
                    pl_go = 1'b1;
                  end
                end
                A_CMD17, A_CMD9: begin
                  if (rx != 8'h00) begin
                    fl_go = 1'b1;
                    fl_err = (after_step == A_CMD17) ? E_CMD17 : E_NO_ERASE;
                  end else begin
                    phase_next = P_START;
                    ms_elapsed_next = 16'd0;
                    pl_go = 1'b1;
                  end
                end
                A_CMD24: begin
                  if (rx != 8'h00) begin
                    fl_go = 1'b1; fl_err = E_CMD24;
                  end else begin
                    phase_next = P_WDATA;
                    byte_count_next = '0;
                    emit = 1'b1;
                    r.tx_valid = 1'b1;
                    r.tx_byte = 8'hfe;
                    r.cs_low = 1'b1;
                    r.wr_ready = 1'b1;
                  end
                end
                A_CMD13: begin
                  if (rx != 8'h00) begin
                    fl_go = 1'b1; fl_err = E_PROG;
                  end else begin
                    phase_next = P_STAT2;
                    pl_go = 1'b1;
                  end
                end
                A_CMD32: begin
                  if (rx != 8'h00) begin
                    fl_go = 1'b1; fl_err = E_ERASE;
                  end else begin
                    sc_go = 1'b1; sc_idx = 6'd33; sc_after = A_CMD33;
                    sc_arg = to_addr(card_kind, erase_end_addr);
                  end
                end
                A_CMD33: begin
                  if (rx != 8'h00) begin
                    fl_go = 1'b1; fl_err = E_ERASE;
                  end else begin
                    sc_go = 1'b1; sc_idx = 6'd38; sc_after = A_CMD38;
                  end
                end
                default: begin
                  if (rx != 8'h00) begin
                    fl_go = 1'b1; fl_err = E_ERASE;
                  end else begin
                    phase_next = P_BUSY;
                    ms_elapsed_next = 16'd0;
                    pl_go = 1'b1;
                  end
                end
              endcase
            end
          end
          P_R7: begin
            byte_count_next = bc_inc;
            last_status_next = rx;
            if (bc_inc < BC_W'(4)) begin
              pl_go = 1'b1;
            end else if (rx != 8'haa) begin
              fl_go = 1'b1; fl_err = E_CMD8;
            end else begin
              card_kind_next = CK_SD2;
              sc_go = 1'b1; sc_idx = 6'd55; sc_after = A_CMD55;
            end
          end
          P_OCR: begin
            if (byte_count == '0 && rx[7:6] == 2'b11) card_kind_next = CK_SDHC;
            byte_count_next = bc_inc;
            if (bc_inc < BC_W'(4)) pl_go = 1'b1;
            else fin_go = 1'b1;
          end
          P_START: begin
            last_status_next = rx;
            if (rx == 8'hff) begin
              if (ms_elapsed > read_to) begin
                fl_go = 1'b1;
                fl_err = (req_op == OP_READ) ? E_GENERAL : E_NO_ERASE;
              end else begin
                pl_go = 1'b1;
              end
            end else if (rx != 8'hfe) begin
              fl_go = 1'b1;
              fl_err = (req_op == OP_READ) ? E_GENERAL : E_NO_ERASE;
            end else begin
              phase_next = (req_op == OP_READ) ? P_DATA : P_CSD;
              byte_count_next = '0;
              pl_go = 1'b1;
            end
          end
          P_DATA: begin
            byte_count_next = bc_inc;
            if (bc_inc >= BC_LAST) begin
              phase_next = P_CRC;
              byte_count_next = '0;
            end
            emit = 1'b1;
            r.tx_valid = 1'b1;
            r.tx_byte = 8'hff;
            r.cs_low = 1'b1;
            r.rd_valid = 1'b1;
            r.rd_byte = rx;
          end
          P_CSD: begin
            // The erase-enable bit sits in byte ten of the CSD.
            if (byte_count == BC_W'(10)) erase_enabled_next = rx[6];
            byte_count_next = bc_inc;
            if (bc_inc >= BC_W'(16)) begin
              phase_next = P_CRC;
              byte_count_next = '0;
            end
            pl_go = 1'b1;
          end
          P_CRC: begin
            byte_count_next = bc_inc;
            if (bc_inc < BC_W'(2)) begin
              pl_go = 1'b1;
            end else if (req_op == OP_READ) begin
              fin_go = 1'b1;
            end else if (!erase_enabled) begin
              fl_go = 1'b1; fl_err = E_NO_ERASE;
            end else begin
              sc_go = 1'b1; sc_idx = 6'd32; sc_after = A_CMD32;
              sc_arg = to_addr(card_kind, erase_start_addr);
            end
          end
          P_WDATA: begin
            if (byte_count >= BC_RESP) begin
              last_status_next = rx;
              if (rx[4:0] != 5'h05) begin
                fl_go = 1'b1; fl_err = E_GENERAL;
              end else begin
                phase_next = P_BUSY;
                ms_elapsed_next = 16'd0;
                pl_go = 1'b1;
              end
            end else begin
              byte_count_next = bc_inc;
              if (bc_inc <= BC_LAST) begin
                emit = 1'b1;
                r.tx_valid = 1'b1;
                r.tx_byte = q_head.wr_byte;
                r.cs_low = 1'b1;
                r.wr_ready = (bc_inc < BC_LAST);
              end else begin
                pl_go = 1'b1;
              end
            end
          end
          P_BUSY: begin
            if (rx == 8'hff) begin
              if (req_op == OP_WRITE) begin
                sc_go = 1'b1; sc_idx = 6'd13; sc_after = A_CMD13;
              end else begin
                fin_go = 1'b1;
              end
            end else if (req_op == OP_WRITE && ms_elapsed >= write_to) begin
              fl_go = 1'b1; fl_err = E_WR_TO;
            end else if (req_op != OP_WRITE && ms_elapsed >= erase_to) begin
              fl_go = 1'b1; fl_err = E_ERASE_TO;
            end else begin
              pl_go = 1'b1;
            end
          end
          P_STAT2: begin
            if (rx != 8'h00) begin
              fl_go = 1'b1; fl_err = E_PROG;
            end else begin
              fin_go = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: begin
        if (ms_elapsed != 16'hffff) ms_elapsed_next = ms_elapsed + 16'd1;
        if (flush_ms != 16'hffff) flush_ms_next = flush_ms + 16'd1;
      end
    endcase

    if (sc_go) begin
      cmd_index_next = sc_idx;
      cmd_argument_next = sc_arg;
      after_step_next = sc_after;
      flush_ms_next = 16'd0;
      phase_next = P_FLUSH;
      pl_go = 1'b1;
    end
    if (fl_go) begin
      phase_next = P_IDLE;
      last_status_next = {4'd0, fl_err};
      emit = 1'b1;
      r.done_res = 1'b1;
      r.error_code = fl_err;
    end
    if (fin_go) begin
      phase_next = P_IDLE;
      emit = 1'b1;
      r.done_res = 1'b1;
      r.ok = 1'b1;
    end
    if (pl_go) begin
      emit = 1'b1;
      r.tx_valid = 1'b1;
      r.tx_byte = 8'hff;
      r.cs_low = 1'b1;
    end
    r.card_type = card_kind_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      card_kind <= 2'd0;
      last_status <= 8'd0;
      ms_elapsed <= 16'd0;
      flush_ms <= 16'd0;
      byte_count <= '0;
      retry_count <= 8'd0;
      cmd_index <= 6'd0;
      cmd_argument <= 32'd0;
      erase_end_addr <= 32'd0;
      erase_start_addr <= 32'd0;
      erase_enabled <= 1'b0;
      after_step <= A_CMD0;
      req_op <= OP_INIT;
      out_valid <= 1'b0;
    end else begin
      // A popped word that emits a result fills the output register; otherwise a waiting result holds until taken.
      out_valid <= (q_pop && emit) || (out_valid && !result.ready);
      if (q_pop) begin
        phase <= phase_next;
        card_kind <= card_kind_next;
        last_status <= last_status_next;
        ms_elapsed <= ms_elapsed_next;
        flush_ms <= flush_ms_next;
        byte_count <= byte_count_next;
        retry_count <= retry_count_next;
        cmd_index <= cmd_index_next;
        cmd_argument <= cmd_argument_next;
        erase_end_addr <= erase_end_addr_next;
        erase_start_addr <= erase_start_addr_next;
        erase_enabled <= erase_enabled_next;
        after_step <= after_step_next;
        req_op <= req_op_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) out_data <= r;
  end

endmodule

// ===== hdl/sdspi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD card SPI host engine checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "sd_card_spi_host_engine_unit_defines.svh"

module sdspi_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  res_valid,
  input logic                  res_ready,
  input sdspi_pkg::out_item_t  res_data
);
  import sdspi_pkg::*;

  logic held, done_w, idle_w, busy_w, link_w, quiet_w, clean_w;

  assign held    = res_valid && !res_ready;
  assign done_w  = res_valid && res_data.done_res;
  assign idle_w  = res_valid && !res_data.tx_valid;
  assign busy_w  = res_valid && !res_data.done_res;
  assign link_w  = res_data.tx_valid || res_data.cs_low;
  assign quiet_w = (res_data.tx_byte == 8'h00) && !res_data.wr_ready;
  assign clean_w = (res_data.error_code == 4'd0) && !res_data.ok;

  `SDSPI_ASSERT_NXT(a_hold, held, res_valid, "result word dropped")
  `SDSPI_ASSERT_IMP(a_done_idle, done_w, !link_w, "completion with a transfer")
  `SDSPI_ASSERT_IMP(a_tx_zero, idle_w, quiet_w, "idle transfer byte set")
  `SDSPI_ASSERT_IMP(a_err_zero, busy_w, clean_w, "status without completion")

endmodule

bind sd_card_spi_host_engine_unit sdspi_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .res_valid(result.valid),
  .res_ready(result.ready),
  .res_data (result.data)
);

// ===== verif/tb_sd_card_spi_host_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD card SPI host engine testbench
// A card responder picks each received byte from the engine's predicted state,
// so that init, read, write and erase sequences run deep with random faults.
// Every result word is checked field by field against an engine model.
// ----------------------------------------------------------------------------
module tb_sd_card_spi_host_engine_unit;
  import sdspi_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASE_ITEMS = 120;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_ERASE = 2'd3;

  localparam logic [3:0] ERR_NONE = 4'd0, ERR_CMD0 = 4'd1, ERR_CMD8 = 4'd2,
    ERR_ACMD41 = 4'd3, ERR_CMD58 = 4'd4, ERR_CMD17 = 4'd5, ERR_CMD24 = 4'd6,
    ERR_WR_TIMEOUT = 4'd7, ERR_PROGRAM = 4'd8, ERR_NO_ERASE = 4'd9,
    ERR_ERASE = 4'd10, ERR_ERASE_TIMEOUT = 4'd11, ERR_BLOCK_ZERO = 4'd12,
    ERR_GENERAL = 4'd15;

  localparam logic [1:0] KIND_NONE = 2'd0, KIND_SD1 = 2'd1, KIND_SD2 = 2'd2,
    KIND_SDHC = 2'd3;

  localparam logic [5:0] SD_CMD0 = 6'd0, SD_CMD8 = 6'd8, SD_CMD9 = 6'd9,
    SD_CMD13 = 6'd13, SD_CMD17 = 6'd17, SD_CMD24 = 6'd24, SD_CMD32 = 6'd32,
    SD_CMD33 = 6'd33, SD_CMD38 = 6'd38, SD_ACMD41 = 6'd41, SD_CMD55 = 6'd55,
    SD_CMD58 = 6'd58;

  localparam logic [7:0] BYTE_IDLE = 8'hff, TOKEN_START = 8'hfe, R1_IDLE = 8'h01,
    R1_READY = 8'h00, R1_ILLEGAL = 8'h05, CHECK_PATTERN = 8'haa, DATA_ACCEPTED = 8'h05;

  typedef enum logic [3:0] {
    PH_IDLE, PH_CLOCKS, PH_FLUSH, PH_SEND, PH_RESP, PH_R7, PH_OCR, PH_START,
    PH_DATA, PH_CSD, PH_CRC, PH_WDATA, PH_BUSY, PH_STAT2
  } phase_e;

  typedef enum logic [3:0] {
    AF_CMD0, AF_CMD8, AF_CMD55, AF_ACMD41, AF_CMD58, AF_CMD17, AF_CMD24,
    AF_CMD13, AF_CMD9, AF_CMD32, AF_CMD33, AF_CMD38
  } after_e;

  class result_board;
    out_item_t pending[$];
    int errors;

    function void note(out_item_t w);
      pending.push_back(w);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task cmp(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check(out_item_t g);
      out_item_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word %h", g));
      end else begin
        e = pending.pop_front();
        cmp("tx_valid", g.tx_valid, e.tx_valid);
        cmp("tx_byte", g.tx_byte, e.tx_byte);
        cmp("cs_low", g.cs_low, e.cs_low);
        cmp("rd_valid", g.rd_valid, e.rd_valid);
        cmp("rd_byte", g.rd_byte, e.rd_byte);
        cmp("wr_ready", g.wr_ready, e.wr_ready);
        cmp("done_res", g.done_res, e.done_res);
        cmp("ok", g.ok, e.ok);
        cmp("error_code", g.error_code, e.error_code);
        cmp("card_type", g.card_type, e.card_type);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  sdspi_in_if  item_ch ();
  sdspi_out_if result_ch ();
  sdspi_cfg_if cfg_ch ();

  sd_card_spi_host_engine_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch.sink),
    .result (result_ch.source),
    .cfg    (cfg_ch.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  result_board board = new();
  int  cycles;
  int  counted;
  int  out_stall;
  bit  no_idle;

  // Engine model state and configuration.
  phase_e      ph;
  after_e      aft;
  logic [1:0]  kind, rop;
  logic [7:0]  status, retries, tries;
  logic [15:0] ms, fms, to_init, to_read, to_write, to_erase, to_flush;
  int          bc;
  logic [5:0]  cidx;
  logic [31:0] carg, e_start, e_end;
  bit          e_en, protect;

  task model_reset();
    to_init = 16'd2000; to_read = 16'd300; to_write = 16'd600; to_erase = 16'd10000;
    to_flush = 16'd300; tries = 8'd255; protect = 1'b0;
    ph = PH_IDLE; aft = AF_CMD0; kind = KIND_NONE; rop = OP_INIT; status = '0;
    retries = '0; ms = '0; fms = '0; bc = 0; cidx = '0; carg = '0;
    e_start = '0; e_end = '0; e_en = 1'b0;
  endtask

  function automatic out_item_t word(bit txv, logic [7:0] tx, bit cs, bit rdv,
                                     logic [7:0] rd, bit wrr, bit done, bit good,
                                     logic [3:0] err);
    return '{txv, tx, cs, rdv, rd, wrr, done, good, err, kind};
  endfunction

  function automatic out_item_t poll_word();
    return word(1, BYTE_IDLE, 1, 0, 0, 0, 0, 0, ERR_NONE);
  endfunction

  function automatic out_item_t finish_ok();
    ph = PH_IDLE;
    return word(0, 0, 0, 0, 0, 0, 1, 1, ERR_NONE);
  endfunction

  function automatic out_item_t fail_with(logic [3:0] err);
    ph = PH_IDLE;
    status = {4'd0, err};
    return word(0, 0, 0, 0, 0, 0, 1, 0, err);
  endfunction

  function automatic logic [31:0] card_addr(logic [31:0] blk);
    return (kind == KIND_SDHC) ? blk : (blk << 9);
  endfunction

  function automatic out_item_t issue_cmd(logic [5:0] idx, logic [31:0] arg, after_e af);
    cidx = idx; carg = arg; aft = af; fms = '0; ph = PH_FLUSH;
    return poll_word();
  endfunction

  function automatic logic [7:0] frame_byte(int b);
    if (b == 0) return {2'b01, cidx};
    if (b <= 4) return 8'(carg >> (8 * (4 - b)));
    if (cidx == SD_CMD0) return 8'h95;
    if (cidx == SD_CMD8) return 8'h87;
    return BYTE_IDLE;
  endfunction

  function automatic out_item_t after_cmd();
    case (aft)
      AF_CMD0: begin
        if (status == R1_IDLE) return issue_cmd(SD_CMD8, 32'h1aa, AF_CMD8);
        if (ms > to_init) return fail_with(ERR_CMD0);
        return issue_cmd(SD_CMD0, 0, AF_CMD0);
      end
      AF_CMD8: begin
        if (status[2]) begin
          kind = KIND_SD1;
          return issue_cmd(SD_CMD55, 0, AF_CMD55);
        end
        ph = PH_R7; bc = 0;
        return poll_word();
      end
      AF_CMD55:
        return issue_cmd(SD_ACMD41, (kind == KIND_SD2) ? 32'h40000000 : 32'h0, AF_ACMD41);
      AF_ACMD41: begin
        if (status == 0) begin
          if (kind == KIND_SD2) return issue_cmd(SD_CMD58, 0, AF_CMD58);
          return finish_ok();
        end
        if (ms > to_init) return fail_with(ERR_ACMD41);
        return issue_cmd(SD_CMD55, 0, AF_CMD55);
      end
      AF_CMD58: begin
        if (status != 0) return fail_with(ERR_CMD58);
        ph = PH_OCR; bc = 0;
        return poll_word();
      end
      AF_CMD17, AF_CMD9: begin
        if (status != 0) return fail_with(aft == AF_CMD17 ? ERR_CMD17 : ERR_NO_ERASE);
        ph = PH_START; ms = '0;
        return poll_word();
      end
      AF_CMD24: begin
        if (status != 0) return fail_with(ERR_CMD24);
        ph = PH_WDATA; bc = 0;
        return word(1, TOKEN_START, 1, 0, 0, 1, 0, 0, ERR_NONE);
      end
      AF_CMD13: begin
        if (status != 0) return fail_with(ERR_PROGRAM);
        ph = PH_STAT2;
        return poll_word();
      end
      AF_CMD32: begin
        if (status != 0) return fail_with(ERR_ERASE);
        return issue_cmd(SD_CMD33, card_addr(e_end), AF_CMD33);
      end
      AF_CMD33: begin
        if (status != 0) return fail_with(ERR_ERASE);
        return issue_cmd(SD_CMD38, 0, AF_CMD38);
      end
      default: begin
        if (status != 0) return fail_with(ERR_ERASE);
        ph = PH_BUSY; ms = '0;
        return poll_word();
      end
    endcase
  endfunction

  function automatic out_item_t on_byte(logic [7:0] rx, logic [7:0] wr);
    case (ph)
      PH_CLOCKS: begin
        bc++;
        if (bc < 10) return word(1, BYTE_IDLE, 0, 0, 0, 0, 0, 0, ERR_NONE);
        ms = '0;
        return issue_cmd(SD_CMD0, 0, AF_CMD0);
      end
      PH_FLUSH: begin
        if (rx == BYTE_IDLE || fms >= to_flush) begin
          ph = PH_SEND; bc = 0;
          return word(1, frame_byte(0), 1, 0, 0, 0, 0, 0, ERR_NONE);
        end
        return poll_word();
      end
      PH_SEND: begin
        bc++;
        if (bc < 6) return word(1, frame_byte(bc), 1, 0, 0, 0, 0, 0, ERR_NONE);
        ph = PH_RESP; retries = '0;
        return poll_word();
      end
      PH_RESP: begin
        status = rx;
        if (rx[7] && retries != tries) begin
          retries++;
          return poll_word();
        end
        return after_cmd();
      end
      PH_R7: begin
        bc++;
        status = rx;
        if (bc < 4) return poll_word();
        if (rx != CHECK_PATTERN) return fail_with(ERR_CMD8);
        kind = KIND_SD2;
        return issue_cmd(SD_CMD55, 0, AF_CMD55);
      end
      PH_OCR: begin
        if (bc == 0 && rx[7:6] == 2'b11) kind = KIND_SDHC;
        bc++;
        if (bc < 4) return poll_word();
        return finish_ok();
      end
      PH_START: begin
        status = rx;
        if (rx == BYTE_IDLE) begin
          if (ms > to_read) return fail_with(rop == OP_READ ? ERR_GENERAL : ERR_NO_ERASE);
          return poll_word();
        end
        if (rx != TOKEN_START) return fail_with(rop == OP_READ ? ERR_GENERAL : ERR_NO_ERASE);
        ph = (rop == OP_READ) ? PH_DATA : PH_CSD;
        bc = 0;
        return poll_word();
      end
      PH_DATA: begin
        bc++;
        if (bc >= BLOCK_BYTES) begin
          ph = PH_CRC; bc = 0;
        end
        return word(1, BYTE_IDLE, 1, 1, rx, 0, 0, 0, ERR_NONE);
      end
      PH_CSD: begin
        if (bc == 10) e_en = rx[6];
        bc++;
        if (bc >= 16) begin
          ph = PH_CRC; bc = 0;
        end
        return poll_word();
      end
      PH_CRC: begin
        bc++;
        if (bc < 2) return poll_word();
        if (rop == OP_READ) return finish_ok();
        if (!e_en) return fail_with(ERR_NO_ERASE);
        return issue_cmd(SD_CMD32, card_addr(e_start), AF_CMD32);
      end
      PH_WDATA: begin
        if (bc >= BLOCK_BYTES + 3) begin
          status = rx;
          if (rx[4:0] != DATA_ACCEPTED[4:0]) return fail_with(ERR_GENERAL);
          ph = PH_BUSY; ms = '0;
          return poll_word();
        end
        bc++;
        if (bc <= BLOCK_BYTES)
          return word(1, wr, 1, 0, 0, bc < BLOCK_BYTES, 0, 0, ERR_NONE);
        return poll_word();
      end
      PH_BUSY: begin
        if (rx == BYTE_IDLE) begin
          if (rop == OP_WRITE) return issue_cmd(SD_CMD13, 0, AF_CMD13);
          return finish_ok();
        end
        if (rop == OP_WRITE) begin
          if (ms >= to_write) return fail_with(ERR_WR_TIMEOUT);
        end else if (ms >= to_erase) begin
          return fail_with(ERR_ERASE_TIMEOUT);
        end
        return poll_word();
      end
      default: begin
        if (rx != 0) return fail_with(ERR_PROGRAM);
        return finish_ok();
      end
    endcase
  endfunction

  function automatic out_item_t on_request(logic [1:0] op, logic [31:0] blk,
                                           logic [31:0] last);
    rop = op;
    case (op)
      OP_INIT: begin
        kind = KIND_NONE; ms = '0; bc = 0; ph = PH_CLOCKS;
        return word(1, BYTE_IDLE, 0, 0, 0, 0, 0, 0, ERR_NONE);
      end
      OP_READ: return issue_cmd(SD_CMD17, card_addr(blk), AF_CMD17);
      OP_WRITE: begin
        if (protect && blk == 0) return fail_with(ERR_BLOCK_ZERO);
        return issue_cmd(SD_CMD24, card_addr(blk), AF_CMD24);
      end
      default: begin
        e_start = blk; e_end = last; e_en = 1'b0;
        return issue_cmd(SD_CMD9, 0, AF_CMD9);
      end
    endcase
  endfunction

  // Returns 1 when the word produces a result, and the result itself.
  function automatic bit engine_step(in_item_t d, output out_item_t r);
    r = '0;
    if (d.command == CMD_REQUEST) begin
      if (ph != PH_IDLE) return 0;
      r = on_request(d.op, d.block_addr, d.last_block);
      return 1;
    end
    if (d.command == CMD_BYTE) begin
      if (ph == PH_IDLE) return 0;
      r = on_byte(d.rx_byte, d.wr_byte);
      return 1;
    end
    if (ms != 16'hffff) ms++;
    if (fms != 16'hffff) fms++;
    return 0;
  endfunction

  // Plausible card answer for the transfer the engine is waiting on.
  function automatic logic [7:0] card_reply();
    int pct;
    logic [7:0] any;
    pct = $urandom_range(0, 99);
    any = 8'($urandom);
    case (ph)
      PH_FLUSH: return (pct < 75) ? BYTE_IDLE : any;
      PH_RESP: begin
        if (pct < 12) return any | 8'h80;
        case (aft)
          AF_CMD0:   return (pct < 85) ? R1_IDLE : R1_READY;
          AF_CMD8:   return (pct < 60) ? R1_IDLE : (pct < 85) ? R1_ILLEGAL : any & 8'h7f;
          AF_ACMD41: return (pct < 55) ? R1_READY : R1_IDLE;
          default:   return (pct < 88) ? R1_READY : any & 8'h7f;
        endcase
      end
      PH_R7:    return (bc == 3 && pct < 85) ? CHECK_PATTERN : any;
      PH_START: return (pct < 70) ? TOKEN_START : (pct < 93) ? BYTE_IDLE : any;
      PH_WDATA:
        return (bc >= BLOCK_BYTES + 3 && pct < 85) ? {any[7:5], DATA_ACCEPTED[4:0]} : any;
      PH_BUSY:  return (pct < 55) ? BYTE_IDLE : any;
      PH_STAT2: return (pct < 85) ? 8'h00 : any;
      default:  return any;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task send(in_item_t d);
    int gap;
    out_item_t r;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= d;
    do @(posedge clk); while (!item_ch.ready);
    if (engine_step(d, r)) board.note(r);
    @(negedge clk);
  endtask

  task drain();
    item_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task write_reg(logic [2:0] idx, logic [15:0] value);
    drain();
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_INIT_TO:  to_init  = value;
      REG_READ_TO:  to_read  = value;
      REG_WRITE_TO: to_write = value;
      REG_ERASE_TO: to_erase = value;
      REG_FLUSH_TO: to_flush = value;
      REG_TRIES:    tries    = value[7:0];
      default:      protect  = value[0];
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task run_request(logic [1:0] op, logic [31:0] blk, logic [31:0] last);
    in_item_t d;
    int pct;
    if ($urandom_range(0, 99) < 30) drain();
    no_idle = ($urandom_range(0, 3) == 0);
    d = '0;
    d.command = CMD_REQUEST; d.op = op; d.block_addr = blk; d.last_block = last;
    d.rx_byte = 8'($urandom); d.wr_byte = 8'($urandom);
    send(d);
    counted++;
    while (ph != PH_IDLE) begin
      pct = $urandom_range(0, 99);
      d.op = 2'($urandom); d.block_addr = $urandom; d.last_block = $urandom;
      d.rx_byte = 8'($urandom); d.wr_byte = 8'($urandom);
      if (pct < 8) begin
        d.command = CMD_TICK;
      end else if (pct < 10) begin
        d.command = CMD_REQUEST;
      end else begin
        d.command = CMD_BYTE;
        d.rx_byte = card_reply();
      end
      send(d);
      if (d.command != CMD_REQUEST) counted++;
    end
  endtask

  task run_random();
    int pct;
    logic [1:0] op;
    logic [31:0] blk;
    counted = 0;
    while (counted < PHASE_ITEMS) begin
      pct = $urandom_range(0, 99);
      op = (pct < 40) ? OP_INIT : (pct < 55) ? OP_READ : (pct < 70) ? OP_WRITE : OP_ERASE;
      pct = $urandom_range(0, 99);
      blk = (pct < 20) ? 32'h0 : (pct < 30) ? 32'hffffffff : $urandom;
      run_request(op, blk, $urandom);
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (out_stall > 0) begin
      result_ch.ready <= 1'b0;
      out_stall--;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** sd_card_spi_host_engine_unit: FAILED **");
      $finish;
    end
    if (!rst && result_ch.valid && result_ch.ready) begin
      board.check(result_ch.data);
      out_stall = no_idle ? 0 : $urandom_range(0, 5);
    end
  end

  initial begin
    in_item_t d;
    item_ch.valid = 1'b0;
    item_ch.data  = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    cycles = 0;
    out_stall = 0;
    no_idle = 1'b0;
    model_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A byte and a tick while idle, then each request kind at address extremes.
    d = '0;
    d.command = CMD_BYTE; d.rx_byte = 8'hff;
    send(d);
    d.command = CMD_TICK;
    send(d);
    run_request(OP_INIT, 32'h0, 32'h0);
    run_request(OP_READ, 32'hffffffff, 32'h0);
    run_request(OP_WRITE, 32'h0, 32'hffffffff);
    run_request(OP_ERASE, 32'h0, 32'hffffffff);
    run_request(OP_ERASE, 32'hffffffff, 32'h0);
    run_request(OP_READ, 32'h0, 32'h0);
    run_random();

    // Timeouts of 1 and a single retry, block zero protected.
    write_reg(REG_INIT_TO, 16'd1);
    write_reg(REG_READ_TO, 16'd1);
    write_reg(REG_WRITE_TO, 16'd1);
    write_reg(REG_ERASE_TO, 16'd1);
    write_reg(REG_FLUSH_TO, 16'd1);
    write_reg(REG_TRIES, 16'd1);
    write_reg(REG_PROTECT, 16'd1);
    run_request(OP_WRITE, 32'h0, 32'h0);
    run_random();

    // Largest settings: init and start-token waits can no longer expire.
    write_reg(REG_INIT_TO, 16'hffff);
    write_reg(REG_READ_TO, 16'hffff);
    write_reg(REG_WRITE_TO, 16'hffff);
    write_reg(REG_ERASE_TO, 16'hffff);
    write_reg(REG_FLUSH_TO, 16'hffff);
    write_reg(REG_TRIES, 16'd255);
    write_reg(REG_PROTECT, 16'd0);
    run_random();

    // Zero flush and busy timeouts end those waits at the first busy byte.
    write_reg(REG_FLUSH_TO, 16'd0);
    write_reg(REG_WRITE_TO, 16'd0);
    write_reg(REG_ERASE_TO, 16'd0);
    write_reg(REG_TRIES, 16'd3);
    write_reg(REG_PROTECT, 16'd1);
    run_random();

    write_reg(REG_INIT_TO, 16'($urandom_range(1, 20)));
    write_reg(REG_READ_TO, 16'($urandom_range(1, 20)));
    write_reg(REG_WRITE_TO, 16'($urandom_range(1, 20)));
    write_reg(REG_ERASE_TO, 16'($urandom_range(1, 20)));
    write_reg(REG_FLUSH_TO, 16'($urandom_range(1, 20)));
    write_reg(REG_TRIES, 16'($urandom_range(1, 10)));
    write_reg(REG_PROTECT, 16'($urandom_range(0, 1)));
    run_random();

    drain();
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("** sd_card_spi_host_engine_unit: PASSED **");
    end else begin
      $display("** sd_card_spi_host_engine_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/sdspi_pkg.sv
hdl/sdspi_if.sv
hdl/sdspi_front.sv
hdl/sdspi_back.sv
hdl/sd_card_spi_host_engine_unit.sv
hdl/sdspi_checker.sv
verif/tb_sd_card_spi_host_engine_unit.sv
